### design/msqm_pkg.sv
package msqm_pkg;

    localparam int NUM_LISTS  = 16;
    localparam int POOL_DEPTH = 1024;
    localparam int WORD_WIDTH = 32;

    localparam int LIST_ID_W = 4;
    localparam int NODE_W    = $clog2(POOL_DEPTH);
    localparam int COUNT_W   = NODE_W + 1;
    localparam int STATUS_W  = 3;

    // Command codes; code three is handled as pop
    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_PUSH   = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic              exists;
        logic              is_queue;
        logic              nonempty;
        logic [NODE_W-1:0] head;
        logic [NODE_W-1:0] tail;
    } list_entry_t;

    typedef struct packed {
        logic              word_en;
        logic [NODE_W-1:0] word_addr;
        logic              link_en;
        logic [NODE_W-1:0] link_addr;
        logic [NODE_W-1:0] link_data;
    } node_wr_t;

endpackage

### design/msqm_list_table.sv
module msqm_list_table
    import msqm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [LIST_ID_W-1:0] rd_id,
    output list_entry_t          rd_entry,
    input  logic                 wr_en,
    input  logic [LIST_ID_W-1:0] wr_id,
    input  list_entry_t          wr_entry
);

    logic              exists_reg   [NUM_LISTS];
    logic              is_queue_reg [NUM_LISTS];
    logic              nonempty_reg [NUM_LISTS];
    logic [NODE_W-1:0] head_reg     [NUM_LISTS];
    logic [NODE_W-1:0] tail_reg     [NUM_LISTS];

    // Look up the addressed list
    always_comb
    begin
        rd_entry.exists   = exists_reg[rd_id];
        rd_entry.is_queue = is_queue_reg[rd_id];
        rd_entry.nonempty = nonempty_reg[rd_id];
        rd_entry.head     = head_reg[rd_id];
        rd_entry.tail     = tail_reg[rd_id];
    end

    // Flags clear on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                exists_reg[i]   <= 1'b0;
                is_queue_reg[i] <= 1'b0;
                nonempty_reg[i] <= 1'b0;
            end
        end
        else if (wr_en)
        begin
            exists_reg[wr_id]   <= wr_entry.exists;
            is_queue_reg[wr_id] <= wr_entry.is_queue;
            nonempty_reg[wr_id] <= wr_entry.nonempty;
        end
    end

    // Head and tail pointers are meaningful only while the list is nonempty
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            head_reg[wr_id] <= wr_entry.head;
            tail_reg[wr_id] <= wr_entry.tail;
        end
    end

endmodule

### design/msqm_node_ram.sv
module msqm_node_ram
    import msqm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [NODE_W-1:0]     rd_addr,
    output logic [WORD_WIDTH-1:0] rd_word,
    output logic [NODE_W-1:0]     rd_link,
    input  node_wr_t              wr,
    input  logic [WORD_WIDTH-1:0] wr_word
);

    logic [WORD_WIDTH-1:0] word_mem [POOL_DEPTH];
    logic [NODE_W-1:0]     link_mem [POOL_DEPTH];

    // Word store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr.word_en)
        begin
            word_mem[wr.word_addr] <= wr_word;
        end
        if (rd_en)
        begin
            rd_word <= word_mem[rd_addr];
        end
    end

    // Link store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr.link_en)
        begin
            link_mem[wr.link_addr] <= wr.link_data;
        end
        if (rd_en)
        begin
            rd_link <= link_mem[rd_addr];
        end
    end

endmodule

### design/multi_stack_queue_manager.sv
// Channel   Handshake             Payload
// command   in_valid / in_ready   operation, list_id, list_kind, push_value
// result    out_valid / out_ready status, popped_value, popped_valid
//
// The accept cycle issues the node memory read; the execute state then uses
// the read data, writes back and loads the result register.
// The registered read of the node memory makes the execute state necessary.
// Reset clears the list flags, the free-list pointer and the node counters.
// An item is taken while a result waits; its execute state holds until the
// result register is free.
module multi_stack_queue_manager
    import msqm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            operation,
    input  logic [LIST_ID_W-1:0]  list_id,
    input  logic                  list_kind,
    input  logic [WORD_WIDTH-1:0] push_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [WORD_WIDTH-1:0] popped_value,
    output logic                  popped_valid
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;

    logic [1:0]            cmd_op_reg;
    logic [LIST_ID_W-1:0]  cmd_id_reg;
    logic                  cmd_kind_reg;
    logic [WORD_WIDTH-1:0] cmd_value_reg;

    logic [NODE_W-1:0]  free_head_reg, free_head_next;
    logic [COUNT_W-1:0] recycled_reg, recycled_next;
    logic [COUNT_W-1:0] fresh_reg, fresh_next;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [WORD_WIDTH-1:0] popped_value_reg, popped_value_next;
    logic                  popped_valid_reg, popped_valid_next;

    logic                  accept;
    logic                  commit;
    logic [LIST_ID_W-1:0]  tbl_rd_id;
    list_entry_t           entry;
    logic                  tbl_wr_en;
    list_entry_t           tbl_wr_entry;
    logic                  ram_rd_en;
    logic [NODE_W-1:0]     ram_rd_addr;
    logic [WORD_WIDTH-1:0] ram_rd_word;
    logic [NODE_W-1:0]     ram_rd_link;
    node_wr_t              ram_wr;
    logic                  have_recycled;
    logic                  have_fresh;
    logic [NODE_W-1:0]     new_node;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    // Look up the incoming list on accept, the held command afterwards
    assign tbl_rd_id = (state_reg == S_IDLE) ? list_id : cmd_id_reg;

    msqm_list_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_id    (tbl_rd_id),
        .rd_entry (entry),
        .wr_en    (tbl_wr_en),
        .wr_id    (cmd_id_reg),
        .wr_entry (tbl_wr_entry)
    );

    // Push reads the free-list link, pop reads the head node
    assign ram_rd_en   = accept;
    assign ram_rd_addr = (operation == OP_PUSH) ? free_head_reg : entry.head;

    msqm_node_ram u_nodes (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_word (ram_rd_word),
        .rd_link (ram_rd_link),
        .wr      (ram_wr),
        .wr_word (cmd_value_reg)
    );

    assign have_recycled = (recycled_reg != '0);
    assign have_fresh    = (fresh_reg < COUNT_W'(POOL_DEPTH));
    assign new_node      = have_recycled ? free_head_reg : fresh_reg[NODE_W-1:0];

    // Modify the list and node state for the held command
    always_comb
    begin
        state_next        = state_reg;
        free_head_next    = free_head_reg;
        recycled_next     = recycled_reg;
        fresh_next        = fresh_reg;
        status_next       = ST_OK;
        popped_value_next = '0;
        popped_valid_next = 1'b0;
        tbl_wr_en         = 1'b0;
        tbl_wr_entry      = entry;
        ram_wr            = '0;

        if (accept)
        begin
            state_next = S_EXEC;
        end

        if (commit)
        begin
            state_next = S_IDLE;
            unique case (cmd_op_reg)
                OP_CREATE:
                begin
                    if (entry.exists)
                    begin
                        status_next = ST_EXISTS;
                    end
                    else
                    begin
                        tbl_wr_en             = 1'b1;
                        tbl_wr_entry.exists   = 1'b1;
                        tbl_wr_entry.is_queue = cmd_kind_reg;
                        tbl_wr_entry.nonempty = 1'b0;
                    end
                end
                OP_PUSH:
                begin
                    if (!entry.exists)
                    begin
                        status_next = ST_UNKNOWN;
                    end
                    else if (!have_recycled && !have_fresh)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        if (have_recycled)
                        begin
                            free_head_next = ram_rd_link;
                            recycled_next  = recycled_reg - COUNT_W'(1);
                        end
                        else
                        begin
                            fresh_next = fresh_reg + COUNT_W'(1);
                        end
                        ram_wr.word_en   = 1'b1;
                        ram_wr.word_addr = new_node;
                        tbl_wr_en        = 1'b1;
                        if (!entry.nonempty)
                        begin
                            tbl_wr_entry.head     = new_node;
                            tbl_wr_entry.tail     = new_node;
                            tbl_wr_entry.nonempty = 1'b1;
                        end
                        else if (entry.is_queue)
                        begin
                            // Chain behind the old tail; the tail link is never read
                            ram_wr.link_en    = 1'b1;
                            ram_wr.link_addr  = entry.tail;
                            ram_wr.link_data  = new_node;
                            tbl_wr_entry.tail = new_node;
                        end
                        else
                        begin
                            ram_wr.link_en    = 1'b1;
                            ram_wr.link_addr  = new_node;
                            ram_wr.link_data  = entry.head;
                            tbl_wr_entry.head = new_node;
                        end
                    end
                end
                default:
                begin
                    if (!entry.exists)
                    begin
                        status_next = ST_UNKNOWN;
                    end
                    else if (!entry.nonempty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        popped_value_next = ram_rd_word;
                        popped_valid_next = 1'b1;
                        tbl_wr_en         = 1'b1;
                        if (entry.head == entry.tail)
                        begin
                            tbl_wr_entry.nonempty = 1'b0;
                        end
                        else
                        begin
                            tbl_wr_entry.head = ram_rd_link;
                        end
                        // Recycle the freed node onto the free list
                        ram_wr.link_en   = 1'b1;
                        ram_wr.link_addr = entry.head;
                        ram_wr.link_data = free_head_reg;
                        free_head_next   = entry.head;
                        recycled_next    = recycled_reg + COUNT_W'(1);
                    end
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            recycled_reg  <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            recycled_reg  <= recycled_next;
            fresh_reg     <= fresh_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the command and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_op_reg    <= operation;
            cmd_id_reg    <= list_id;
            cmd_kind_reg  <= list_kind;
            cmd_value_reg <= push_value;
        end
        if (commit)
        begin
            status_reg       <= status_next;
            popped_value_reg <= popped_value_next;
            popped_valid_reg <= popped_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_value_reg;
    assign popped_valid = popped_valid_reg;

endmodule

### verif/testbench.sv
module testbench;
    import msqm_pkg::*;

    // Pop alias and list kinds; code three behaves as a pop
    localparam logic [1:0] OP_POP_ALIAS = 2'd3;
    localparam logic       KIND_STACK   = 1'b0;
    localparam logic       KIND_QUEUE   = 1'b1;

    localparam int ITEM_TARGET   = 1900;
    localparam int IDLE_PERCENT  = 34;
    localparam int STEADY_FIRST  = 700;
    localparam int STEADY_LAST   = 1000;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic [WORD_WIDTH-1:0] word;
        logic                  word_valid;
    } outcome_t;

    // Shadow of the list table and node pool, with the outcomes still owed
    class list_pool_scoreboard;
        logic                  exists   [NUM_LISTS];
        logic                  is_queue [NUM_LISTS];
        logic                  nonempty [NUM_LISTS];
        logic [NODE_W-1:0]     head     [NUM_LISTS];
        logic [NODE_W-1:0]     tail     [NUM_LISTS];
        logic [WORD_WIDTH-1:0] word_mem [POOL_DEPTH];
        logic [NODE_W-1:0]     link_mem [POOL_DEPTH];
        logic [NODE_W-1:0]     free_head;
        int                    recycled;
        int                    fresh;
        outcome_t              outcomes_due[$];
        int                    results_seen;
        int                    fail_count;

        function new();
            foreach (exists[i])
            begin
                exists[i]   = 1'b0;
                is_queue[i] = 1'b0;
                nonempty[i] = 1'b0;
                head[i]     = '0;
                tail[i]     = '0;
            end
            free_head    = '0;
            recycled     = 0;
            fresh        = 0;
            results_seen = 0;
            fail_count   = 0;
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        function int nodes_in_use();
            return fresh - recycled;
        endfunction

        // Pick a list that exists (and holds words if asked), else any id
        function logic [LIST_ID_W-1:0] live_id(bit want_words);
            logic [LIST_ID_W-1:0] id;
            id = LIST_ID_W'($urandom_range(0, NUM_LISTS - 1));
            repeat (12)
            begin
                if (exists[id] && (!want_words || nonempty[id]))
                    return id;
                id = LIST_ID_W'($urandom_range(0, NUM_LISTS - 1));
            end
            return id;
        endfunction

        // Apply one accepted command to the shadow state and queue its outcome
        function void apply_command(logic [1:0] op, logic [LIST_ID_W-1:0] id,
                                    logic kind, logic [WORD_WIDTH-1:0] value);
            outcome_t          due;
            logic [NODE_W-1:0] node;
            due = '{ST_OK, '0, 1'b0};
            node = '0;
            if (int'(id) >= NUM_LISTS)
                due.status = ST_UNKNOWN;
            else if (op == OP_CREATE)
            begin
                if (exists[id])
                    due.status = ST_EXISTS;
                else
                begin
                    exists[id]   = 1'b1;
                    is_queue[id] = kind;
                    nonempty[id] = 1'b0;
                end
            end
            else if (!exists[id])
                due.status = ST_UNKNOWN;
            else if (op == OP_PUSH)
            begin
                // Take a recycled node first, then a fresh one
                if (recycled > 0)
                begin
                    node      = free_head;
                    free_head = link_mem[node];
                    recycled--;
                end
                else if (fresh < POOL_DEPTH)
                begin
                    node = NODE_W'(fresh);
                    fresh++;
                end
                else
                    due.status = ST_FULL;
                if (due.status == ST_OK)
                begin
                    word_mem[node] = value;
                    link_mem[node] = '0;
                    if (!nonempty[id])
                    begin
                        head[id]     = node;
                        tail[id]     = node;
                        nonempty[id] = 1'b1;
                    end
                    else if (is_queue[id])
                    begin
                        link_mem[tail[id]] = node;
                        tail[id]           = node;
                    end
                    else
                    begin
                        link_mem[node] = head[id];
                        head[id]       = node;
                    end
                end
            end
            else
            begin
                // Pop from the head and hand the node back to the free list
                if (!nonempty[id])
                    due.status = ST_EMPTY;
                else
                begin
                    node           = head[id];
                    due.word       = word_mem[node];
                    due.word_valid = 1'b1;
                    if (node == tail[id])
                        nonempty[id] = 1'b0;
                    else
                        head[id] = link_mem[node];
                    link_mem[node] = free_head;
                    free_head      = node;
                    recycled++;
                end
            end
            outcomes_due.push_back(due);
        endfunction

        task report(string what);
            $display("mismatch on result %0d: %s", results_seen, what);
            fail_count++;
        endtask

        // Compare one accepted result with the oldest outcome owed
        task check_outcome(logic [STATUS_W-1:0] st, logic [WORD_WIDTH-1:0] word,
                           logic word_valid);
            outcome_t due;
            results_seen++;
            if (outcomes_due.size() == 0)
            begin
                report("result with no command outstanding");
                return;
            end
            due = outcomes_due.pop_front();
            if (st !== due.status)
                report($sformatf("status %0d, want %0d", st, due.status));
            if (word !== due.word)
                report($sformatf("popped_value %h, want %h", word, due.word));
            if (word_valid !== due.word_valid)
                report($sformatf("popped_valid %b, want %b", word_valid,
                                 due.word_valid));
        endtask
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [1:0]            operation    = OP_CREATE;
    logic [LIST_ID_W-1:0]  list_id      = '0;
    logic                  list_kind    = KIND_STACK;
    logic [WORD_WIDTH-1:0] push_value   = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [WORD_WIDTH-1:0] popped_value;
    logic                  popped_valid;

    list_pool_scoreboard board = new();
    int sent = 0;

    multi_stack_queue_manager DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .list_id      (list_id),
        .list_kind    (list_kind),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .popped_valid (popped_valid)
    );

    always #5 clk = ~clk;

    // Offer one command item, idling at random first outside the steady stretch, and note it once taken
    task issue(logic [1:0] op, logic [LIST_ID_W-1:0] id, logic kind,
               logic [WORD_WIDTH-1:0] value);
        if (sent < STEADY_FIRST || sent >= STEADY_LAST)
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        @(negedge clk);
        in_valid   <= 1'b1;
        operation  <= op;
        list_id    <= id;
        list_kind  <= kind;
        push_value <= value;
        do
            @(posedge clk);
        while (!in_ready);
        board.apply_command(op, id, kind, value);
        sent++;
    endtask

    // Drop valid and hold until every owed result has come back
    task drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    function logic [WORD_WIDTH-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return WORD_WIDTH'($urandom);
        endcase
    endfunction

    // Mostly pushes and pops on live lists, with some creates and stray ids
    task random_command();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            issue(OP_CREATE, LIST_ID_W'($urandom_range(0, NUM_LISTS - 1)),
                  1'($urandom_range(0, 1)), random_word());
        else if (pick < 10)
            issue(pick < 8 ? OP_PUSH : OP_POP,
                  LIST_ID_W'($urandom_range(0, NUM_LISTS - 1)),
                  1'($urandom_range(0, 1)), random_word());
        else if (pick < 58)
            issue(OP_PUSH, board.live_id(1'b0), 1'($urandom_range(0, 1)),
                  random_word());
        else
            issue(pick < 92 ? OP_POP : OP_POP_ALIAS, board.live_id(1'b1),
                  1'($urandom_range(0, 1)), random_word());
    endtask

    // Accept results at random, with one long hold-off and a steady stretch
    initial
    begin
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && board.results_seen >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            if (board.results_seen >= STEADY_FIRST && board.results_seen < STEADY_LAST)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_outcome(status, popped_value, popped_valid);
        end
    end

    // Stimulus
    initial
    begin
        int fill_count;
        int tail_count;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Unknown ids before any list exists
        issue(OP_PUSH,      4'd3,  KIND_STACK, '1);
        issue(OP_POP,       4'd3,  KIND_QUEUE, '0);
        issue(OP_POP_ALIAS, 4'd15, KIND_STACK, '0);
        // Create both kinds, then a duplicate create
        issue(OP_CREATE,    4'd0,  KIND_STACK, '1);
        issue(OP_CREATE,    4'd15, KIND_QUEUE, '0);
        issue(OP_CREATE,    4'd0,  KIND_QUEUE, '1);
        // Stack: empty pop, last-in-first-out order, last element, empty again
        issue(OP_POP,       4'd0,  KIND_STACK, '0);
        issue(OP_PUSH,      4'd0,  KIND_STACK, '0);
        issue(OP_PUSH,      4'd0,  KIND_QUEUE, '1);
        issue(OP_PUSH,      4'd0,  KIND_STACK, 32'hA5A5_A5A5);
        issue(OP_POP,       4'd0,  KIND_STACK, '0);
        issue(OP_POP_ALIAS, 4'd0,  KIND_STACK, '1);
        issue(OP_POP,       4'd0,  KIND_STACK, '0);
        issue(OP_POP,       4'd0,  KIND_STACK, '0);
        // Queue: first-in-first-out order, then reuse of recycled nodes
        issue(OP_PUSH,      4'd15, KIND_STACK, 32'h0000_0001);
        issue(OP_PUSH,      4'd15, KIND_STACK, 32'h8000_0000);
        issue(OP_PUSH,      4'd15, KIND_STACK, 32'h5A5A_5A5A);
        issue(OP_POP,       4'd15, KIND_STACK, '0);
        issue(OP_POP_ALIAS, 4'd15, KIND_STACK, '0);
        issue(OP_POP,       4'd15, KIND_STACK, '0);
        issue(OP_PUSH,      4'd15, KIND_QUEUE, 32'h0000_0007);
        issue(OP_CREATE,    4'd15, KIND_STACK, '0);
        issue(OP_POP,       4'd15, KIND_QUEUE, '0);

        repeat (350)
            random_command();

        // Pause until idle, then exhaust the pool and push past the limit
        drain();
        fill_count = POOL_DEPTH - board.nodes_in_use() + 4;
        repeat (fill_count)
            issue(OP_PUSH, board.live_id(1'b0), 1'($urandom_range(0, 1)),
                  random_word());

        // Hand nodes back, then mix again over the recycled pool
        repeat (300)
            issue($urandom_range(0, 3) == 0 ? OP_POP_ALIAS : OP_POP,
                  board.live_id(1'b1), 1'($urandom_range(0, 1)), random_word());
        tail_count = (ITEM_TARGET - sent > 150) ? ITEM_TARGET - sent : 150;
        repeat (tail_count)
            random_command();

        drain();
        repeat (8)
            @(negedge clk);
        if (board.fail_count == 0)
            $display("multi_stack_queue_manager verification clean");
        else
            $display("multi_stack_queue_manager verification failed");
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #3000000;
        $display("multi_stack_queue_manager verification failed");
        $finish;
    end

endmodule
